@@ design/swept_circle_segment_bounce_macros.svh @@
// Assertion macros shared by the swept circle segment bounce RTL.
`ifndef SWEPT_CIRCLE_SEGMENT_BOUNCE_MACROS_SVH
`define SWEPT_CIRCLE_SEGMENT_BOUNCE_MACROS_SVH

// same-cycle implication, checked on the rising clock edge outside reset
`define SCSB_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCSB_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/scsb_pkg.sv @@
// Types, codes and helper functions of the swept circle segment bounce block.
package scsb_pkg;

   localparam logic [1:0] ACT_ARM     = 2'd0;
   localparam logic [1:0] ACT_TICK    = 2'd1;
   localparam logic [1:0] ACT_COLLIDE = 2'd2;

   localparam logic [2:0] CSR_START_X  = 3'd0;
   localparam logic [2:0] CSR_START_Y  = 3'd1;
   localparam logic [2:0] CSR_END_X    = 3'd2;
   localparam logic [2:0] CSR_END_Y    = 3'd3;
   localparam logic [2:0] CSR_LIFE     = 3'd4;
   localparam logic [2:0] CSR_BLINK    = 3'd5;
   localparam logic [2:0] CSR_CURVE    = 3'd6;
   localparam logic [2:0] CSR_OFFSET   = 3'd7;

   // quotient bits of the divider, root bits of the square root
   localparam int DIV_STEPS  = 17;
   localparam int SQRT_STEPS = 25;

   typedef enum logic {
      OP_DIV,
      OP_SQRT
   } iter_op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ARM0, ST_ARM1, ST_ARM2, ST_ARM3, ST_ARM4, ST_ARM5,
      ST_TICK,
      ST_COL0, ST_COL1, ST_COL2, ST_COL3, ST_COL4, ST_COL5, ST_COL6,
      ST_COL7, ST_COL8, ST_COL9, ST_COL10, ST_COL11, ST_COL12, ST_COL13,
      ST_COL14, ST_COL15, ST_COL16, ST_COL17,
      ST_EMIT
   } state_type;

   // v / 2^s, nearest, halves away from zero
   function automatic logic signed [63:0] rnd_shift(logic signed [63:0] v, int s);
      logic [63:0] m;
      m = v[63] ? 64'(-v) : 64'(v);
      m = (m + (64'd1 << (s - 1))) >> s;
      return v[63] ? -signed'(m) : signed'(m);
   endfunction

   function automatic logic [23:0] sat24(logic signed [63:0] v);
      if (v > 64'sd8388607) return 24'h7FFFFF;
      if (v < -64'sd8388608) return 24'h800000;
      return v[23:0];
   endfunction

   function automatic logic [23:0] sat_add24(logic [23:0] a, logic [23:0] b);
      logic [24:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[24] ? 24'hFFFFFF : s[23:0];
   endfunction

endpackage

@@ design/scsb_mul.sv @@
// Shared signed multiplier with registered product.
module scsb_mul import scsb_pkg::*; (
   input  logic               clock,
   input  logic signed [35:0] a,
   input  logic signed [25:0] b,
   output logic signed [61:0] p
);

   logic signed [61:0] p_ff, p_in;

   assign p_in = a * b;
   assign p    = p_ff;

   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end

endmodule

@@ design/scsb_iter.sv @@
// Bit-serial restoring divider and square root sharing one compare/subtract.
module scsb_iter import scsb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  iter_op_type mode,
   input  logic [61:0] num,   // dividend, or radicand in the low 50 bits
   input  logic [45:0] den,
   output logic        busy,
   output logic [24:0] res
);

   logic        busy_ff, busy_in;
   iter_op_type mode_ff, mode_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [45:0] rem_ff, rem_in;
   logic [49:0] src_ff, src_in;
   logic [24:0] res_ff, res_in;
   logic [45:0] den_ff, den_in;

   logic [47:0] lhs, rhs, diff;
   logic        ge;

   always_comb begin
      if (mode_ff == OP_DIV) begin
         lhs = {1'b0, rem_ff, src_ff[49]};
         rhs = {2'b00, den_ff};
      end else begin
         lhs = {rem_ff, src_ff[49:48]};
         rhs = {21'd0, res_ff, 2'b01};
      end
      diff = lhs - rhs;
      ge   = lhs >= rhs;
   end

   always_comb begin
      busy_in = busy_ff;
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      src_in  = src_ff;
      res_in  = res_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         mode_in = mode;
         den_in  = den;
         res_in  = '0;
         if (mode == OP_DIV) begin
            // quotient fits DIV_STEPS bits, so the top part is already below den
            rem_in = 46'(num[61:DIV_STEPS]);
            src_in = {num[DIV_STEPS-1:0], (50 - DIV_STEPS)'(0)};
            cnt_in = 5'(DIV_STEPS - 1);
         end else begin
            rem_in = '0;
            src_in = num[49:0];
            cnt_in = 5'(SQRT_STEPS - 1);
         end
      end else if (busy_ff) begin
         rem_in = ge ? diff[45:0] : lhs[45:0];
         res_in = {res_ff[23:0], ge};
         src_in = (mode_ff == OP_DIV) ? {src_ff[48:0], 1'b0} : {src_ff[47:0], 2'b00};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      mode_ff <= mode_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      src_ff  <= src_in;
      res_ff  <= res_in;
      den_ff  <= den_in;
   end

   assign busy = busy_ff;
   assign res  = res_ff;

endmodule

@@ design/swept_circle_segment_bounce.sv @@
// Top level: swept circle against a timed line segment, with bounce response.
//
// req channel: one item per command. tuser carries the action (arm, tick,
// collide); tdata carries tick length, circle centre now and next, radius.
// rsp channel: exactly one result item per request item with the hit flag,
// bounce velocity, bend point and line status.
// csr port: write-only registers (endpoints, life, blink and curve periods,
// curve offset); user must write only while no item is in flight (not enforced).
// Result timing by action: tick and unused codes go straight to the result;
// collide on a hit waits on the 17-step divider for the crossing time (a miss
// ends sooner), arm on the 25-step square root plus two 17-step divisions for
// the normal (the divisions are skipped for a zero-length line).
// One item is worked on at a time; req_tready is high only when idle, which
// starts with the cycle the result is loaded; no new item is taken before that.
// A single registered multiplier and one bit-serial div/sqrt unit are
// stepped by the sequencer below.
// A finished result sits in the output register; if rsp_tready is low the
// sequencer holds there, and the next item is accepted once it is loaded.
// Reset (synchronous) restores register defaults, clears the segment and
// all timers and flags; the line is not alive until an arm item.
`include "swept_circle_segment_bounce_macros.svh"

module swept_circle_segment_bounce import scsb_pkg::*; #(
   parameter int BOUNCE_GAIN_Q8         = 16,
   parameter int CURVE_LIFE_FRACTION_Q8 = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // elapsed, ball_x, ball_y, ball_next_x, ball_next_y, ball_radius, pad
   input  logic [135:0]  req_tdata,
   // action
   input  logic [1:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // collided, bounce_x, bounce_y, bend_x, bend_y, alive, expired,
   // blink_on, bend_on, pad
   output logic [103:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [2:0]    csr_index,
   input  logic [23:0]   csr_wdata
);

   state_type state_ff, state_in;

   // registers
   logic signed [23:0] sx_ff, sx_in, sy_ff, sy_in, ex_ff, ex_in, ey_ff, ey_in;
   logic [23:0] life_time_ff, life_time_in, blink_per_ff, blink_per_in;
   logic [23:0] curve_per_ff, curve_per_in;
   logic [15:0] off_ff, off_in;

   // item
   logic [15:0] elapsed_ff, elapsed_in;
   logic signed [23:0] bx_ff, bx_in, by_ff, by_in, bnx_ff, bnx_in, bny_ff, bny_in;
   logic [22:0] rad_ff, rad_in;

   // segment
   logic signed [23:0] org_x_ff, org_x_in, org_y_ff, org_y_in;
   logic signed [24:0] dir_x_ff, dir_x_in, dir_y_ff, dir_y_in;
   logic [49:0] lensq_ff, lensq_in;
   logic [24:0] len_ff, len_in;
   logic signed [17:0] nrm_x_ff, nrm_x_in, nrm_y_ff, nrm_y_in;

   // timers, bend point, flags
   logic [23:0] life_ff, life_in, blink_t_ff, blink_t_in, bend_t_ff, bend_t_in;
   logic [23:0] bend_x_ff, bend_x_in, bend_y_ff, bend_y_in;
   logic alive_ff, alive_in, expired_ff, expired_in, hit_ff, hit_in;
   logic blinking_ff, blinking_in, blink_on_ff, blink_on_in, bend_on_ff, bend_on_in;

   // work registers
   logic signed [61:0] acc_ff, acc_in;
   logic signed [47:0] dn_ff, dn_in, num_ff, num_in, den_ff, den_in;
   logic signed [17:0] snx_ff, snx_in, sny_ff, sny_in;
   logic signed [35:0] gnx_ff, gnx_in, gny_ff, gny_in;
   logic signed [19:0] offx_ff, offx_in, offy_ff, offy_in;
   logic [23:0] bnc_x_ff, bnc_x_in, bnc_y_ff, bnc_y_in;
   logic coll_ff, coll_in;

   // result
   logic rsp_valid_ff, rsp_valid_in;
   logic [103:0] rsp_data_ff, rsp_data_in;

   // shared units
   logic signed [35:0] mul_a;
   logic signed [25:0] mul_b;
   logic signed [61:0] mul_p;
   logic        it_start, it_busy;
   iter_op_type it_mode;
   logic [61:0] it_num;
   logic [45:0] it_den;
   logic [24:0] it_res;

   logic signed [24:0] dx_c, dy_c, ex_c, ey_c, mx_c, my_c;

   scsb_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (mul_p)
   );

   scsb_iter u_iter (
      .clock (clock),
      .reset (reset),
      .start (it_start),
      .mode  (it_mode),
      .num   (it_num),
      .den   (it_den),
      .busy  (it_busy),
      .res   (it_res)
   );

   assign dx_c = 25'(bx_ff) - 25'(org_x_ff);
   assign dy_c = 25'(by_ff) - 25'(org_y_ff);
   assign ex_c = 25'(bnx_ff) - 25'(org_x_ff);
   assign ey_c = 25'(bny_ff) - 25'(org_y_ff);
   assign mx_c = 25'(bnx_ff) - 25'(bx_ff);
   assign my_c = 25'(bny_ff) - 25'(by_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      logic signed [23:0] ax_v, ay_v, bxe_v, bye_v;
      logic signed [24:0] dxv, dyv;
      logic signed [63:0] sum_w, dnow_w, dnext_w, num_w, den_w, thr_w;
      logic [24:0] mag_v;
      logic signed [17:0] q18;
      logic flip_v, blk_v;
      logic [23:0] dt24, life_v, t_v;

      state_in     = state_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ex_in        = ex_ff;
      ey_in        = ey_ff;
      life_time_in = life_time_ff;
      blink_per_in = blink_per_ff;
      curve_per_in = curve_per_ff;
      off_in       = off_ff;
      elapsed_in   = elapsed_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      bnx_in       = bnx_ff;
      bny_in       = bny_ff;
      rad_in       = rad_ff;
      org_x_in     = org_x_ff;
      org_y_in     = org_y_ff;
      dir_x_in     = dir_x_ff;
      dir_y_in     = dir_y_ff;
      lensq_in     = lensq_ff;
      len_in       = len_ff;
      nrm_x_in     = nrm_x_ff;
      nrm_y_in     = nrm_y_ff;
      life_in      = life_ff;
      blink_t_in   = blink_t_ff;
      bend_t_in    = bend_t_ff;
      bend_x_in    = bend_x_ff;
      bend_y_in    = bend_y_ff;
      alive_in     = alive_ff;
      expired_in   = expired_ff;
      hit_in       = hit_ff;
      blinking_in  = blinking_ff;
      blink_on_in  = blink_on_ff;
      bend_on_in   = bend_on_ff;
      acc_in       = acc_ff;
      dn_in        = dn_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      snx_in       = snx_ff;
      sny_in       = sny_ff;
      gnx_in       = gnx_ff;
      gny_in       = gny_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      bnc_x_in     = bnc_x_ff;
      bnc_y_in     = bnc_y_ff;
      coll_in      = coll_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      mul_a    = '0;
      mul_b    = '0;
      it_start = 1'b0;
      it_mode  = OP_DIV;
      it_num   = '0;
      it_den   = '0;

      ax_v    = '0;
      ay_v    = '0;
      bxe_v   = '0;
      bye_v   = '0;
      dxv     = '0;
      dyv     = '0;
      sum_w   = 64'(acc_ff) + 64'(mul_p);
      dnow_w  = '0;
      dnext_w = '0;
      num_w   = '0;
      den_w   = '0;
      thr_w   = '0;
      mag_v   = '0;
      q18     = signed'(18'(it_res));
      flip_v  = 1'b0;
      blk_v   = blinking_ff;
      dt24    = 24'(elapsed_ff);
      life_v  = life_ff;
      t_v     = '0;

      // the user must issue register writes only while idle; the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            CSR_START_X: sx_in        = csr_wdata;
            CSR_START_Y: sy_in        = csr_wdata;
            CSR_END_X:   ex_in        = csr_wdata;
            CSR_END_Y:   ey_in        = csr_wdata;
            CSR_LIFE:    life_time_in = csr_wdata;
            CSR_BLINK:   blink_per_in = csr_wdata;
            CSR_CURVE:   curve_per_in = csr_wdata;
            CSR_OFFSET:  off_in       = csr_wdata[15:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               elapsed_in = req_tdata[15:0];
               bx_in      = req_tdata[39:16];
               by_in      = req_tdata[63:40];
               bnx_in     = req_tdata[87:64];
               bny_in     = req_tdata[111:88];
               rad_in     = req_tdata[134:112];
               coll_in    = 1'b0;
               bnc_x_in   = '0;
               bnc_y_in   = '0;
               case (req_tuser)
                  ACT_ARM:     state_in = ST_ARM0;
                  ACT_TICK:    state_in = ST_TICK;
                  ACT_COLLIDE: state_in = ST_COL0;
                  default:     state_in = ST_EMIT;
               endcase
            end
         end

         // ---- arm: order endpoints, length by sqrt, normal by two divides
         ST_ARM0: begin
            if (sx_ff > ex_ff) begin
               ax_v = ex_ff; ay_v = ey_ff; bxe_v = sx_ff; bye_v = sy_ff;
            end else begin
               ax_v = sx_ff; ay_v = sy_ff; bxe_v = ex_ff; bye_v = ey_ff;
            end
            dxv = 25'(bxe_v) - 25'(ax_v);
            dyv = 25'(bye_v) - 25'(ay_v);
            org_x_in    = ax_v;
            org_y_in    = ay_v;
            dir_x_in    = dxv;
            dir_y_in    = dyv;
            mul_a       = 36'(dxv);
            mul_b       = 26'(dxv);
            bend_x_in   = '0;
            bend_y_in   = '0;
            life_in     = '0;
            blink_t_in  = '0;
            bend_t_in   = '0;
            alive_in    = 1'b1;
            expired_in  = 1'b0;
            hit_in      = 1'b0;
            blinking_in = 1'b0;
            blink_on_in = 1'b0;
            bend_on_in  = 1'b0;
            state_in    = ST_ARM1;
         end
         ST_ARM1: begin
            acc_in   = mul_p;
            mul_a    = 36'(dir_y_ff);
            mul_b    = 26'(dir_y_ff);
            state_in = ST_ARM2;
         end
         ST_ARM2: begin
            lensq_in = sum_w[49:0];
            it_start = 1'b1;
            it_mode  = OP_SQRT;
            it_num   = 62'(sum_w[49:0]);
            state_in = ST_ARM3;
         end
         ST_ARM3: begin
            if (!it_busy) begin
               len_in = it_res;
               if (it_res == '0) begin
                  nrm_x_in = '0;
                  nrm_y_in = '0;
                  state_in = ST_EMIT;
               end else begin
                  mag_v    = dir_y_ff[24] ? 25'(-dir_y_ff) : 25'(dir_y_ff);
                  it_start = 1'b1;
                  it_num   = (62'(mag_v) << 16) + 62'(it_res >> 1);
                  it_den   = 46'(it_res);
                  state_in = ST_ARM4;
               end
            end
         end
         ST_ARM4: begin
            if (!it_busy) begin
               nrm_x_in = dir_y_ff[24] ? -q18 : q18;
               mag_v    = dir_x_ff[24] ? 25'(-dir_x_ff) : 25'(dir_x_ff);
               it_start = 1'b1;
               it_num   = (62'(mag_v) << 16) + 62'(len_ff >> 1);
               it_den   = 46'(len_ff);
               state_in = ST_ARM5;
            end
         end
         ST_ARM5: begin
            if (!it_busy) begin
               // left normal y comes from -dir_x
               nrm_y_in = dir_x_ff[24] ? q18 : -q18;
               state_in = ST_EMIT;
            end
         end

         // ---- tick
         ST_TICK: begin
            if (alive_ff && !expired_ff) begin
               life_v  = sat_add24(life_ff, dt24);
               life_in = life_v;
               if (hit_ff) begin
                  t_v = sat_add24(bend_t_ff, dt24);
                  if (t_v > curve_per_ff) begin
                     bend_t_in  = '0;
                     bend_on_in = !bend_on_ff;
                  end else begin
                     bend_t_in = t_v;
                  end
               end else if ({life_v, 2'b00} >
                            ({2'b00, life_time_ff} + {1'b0, life_time_ff, 1'b0})) begin
                  blk_v = 1'b1;
               end
               blinking_in = blk_v;
               if (life_v > life_time_ff) begin
                  alive_in   = 1'b0;
                  expired_in = 1'b1;
               end else if (blk_v) begin
                  t_v = sat_add24(blink_t_ff, dt24);
                  if (t_v > blink_per_ff) begin
                     blink_t_in  = '0;
                     blink_on_in = !blink_on_ff;
                  end else begin
                     blink_t_in = t_v;
                  end
               end
            end
            state_in = ST_EMIT;
         end

         // ---- collide: projection, normal distances, then the response
         ST_COL0: begin
            mul_a    = 36'(dx_c);
            mul_b    = 26'(dir_x_ff);
            state_in = ST_COL1;
         end
         ST_COL1: begin
            acc_in   = mul_p;
            mul_a    = 36'(dy_c);
            mul_b    = 26'(dir_y_ff);
            state_in = ST_COL2;
         end
         ST_COL2: begin
            if (hit_ff || lensq_ff == '0 || sum_w < 0 ||
                sum_w > signed'(64'(lensq_ff))) begin
               state_in = ST_EMIT;
            end else begin
               mul_a    = 36'(dx_c);
               mul_b    = 26'(nrm_x_ff);
               state_in = ST_COL3;
            end
         end
         ST_COL3: begin
            acc_in   = mul_p;
            mul_a    = 36'(dy_c);
            mul_b    = 26'(nrm_y_ff);
            state_in = ST_COL4;
         end
         ST_COL4: begin
            dn_in    = 48'(sum_w);
            mul_a    = 36'(ex_c);
            mul_b    = 26'(nrm_x_ff);
            state_in = ST_COL5;
         end
         ST_COL5: begin
            acc_in   = mul_p;
            mul_a    = 36'(ey_c);
            mul_b    = 26'(nrm_y_ff);
            state_in = ST_COL6;
         end
         ST_COL6: begin
            // face the normal toward the current centre
            flip_v  = !(dn_ff > 0);
            dnow_w  = flip_v ? -64'(dn_ff) : 64'(dn_ff);
            dnext_w = flip_v ? -sum_w : sum_w;
            num_w   = signed'(64'(rad_ff) << 16) - dnow_w;
            den_w   = dnext_w - dnow_w;
            num_in  = 48'(num_w);
            den_in  = 48'(den_w);
            snx_in  = flip_v ? -nrm_x_ff : nrm_x_ff;
            sny_in  = flip_v ? -nrm_y_ff : nrm_y_ff;
            if (den_w < 0 && num_w < 0 && num_w > den_w) begin
               state_in = ST_COL7;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_COL7: begin
            hit_in      = 1'b1;
            blinking_in = 1'b1;
            bend_on_in  = 1'b1;
            mul_a       = 36'(life_time_ff);
            mul_b       = 26'(CURVE_LIFE_FRACTION_Q8);
            // crossing time t = |num| / |den| in Q0.16, runs in the background
            it_start    = 1'b1;
            it_num      = 62'((-64'(num_ff)) << 16);
            it_den      = 46'(-64'(den_ff));
            state_in    = ST_COL8;
         end
         ST_COL8: begin
            thr_w = 64'(mul_p) >>> 8;
            if (signed'(64'(life_ff)) < thr_w) life_in = thr_w[23:0];
            mul_a    = 36'(snx_ff);
            mul_b    = 26'(BOUNCE_GAIN_Q8);
            state_in = ST_COL9;
         end
         ST_COL9: begin
            gnx_in   = 36'(mul_p);
            mul_a    = 36'(sny_ff);
            mul_b    = 26'(BOUNCE_GAIN_Q8);
            state_in = ST_COL10;
         end
         ST_COL10: begin
            gny_in   = 36'(mul_p);
            mul_a    = gnx_ff;
            mul_b    = 26'(len_ff);
            state_in = ST_COL11;
         end
         ST_COL11: begin
            bnc_x_in = sat24(rnd_shift(64'(mul_p), 24));
            mul_a    = gny_ff;
            mul_b    = 26'(len_ff);
            state_in = ST_COL12;
         end
         ST_COL12: begin
            bnc_y_in = sat24(rnd_shift(64'(mul_p), 24));
            mul_a    = 36'(snx_ff);
            mul_b    = 26'(off_ff);
            state_in = ST_COL13;
         end
         ST_COL13: begin
            offx_in  = 20'(rnd_shift(64'(mul_p), 16));
            mul_a    = 36'(sny_ff);
            mul_b    = 26'(off_ff);
            state_in = ST_COL14;
         end
         ST_COL14: begin
            offy_in  = 20'(rnd_shift(64'(mul_p), 16));
            state_in = ST_COL15;
         end
         ST_COL15: begin
            if (!it_busy) begin
               mul_a    = 36'(it_res);
               mul_b    = 26'(mx_c);
               state_in = ST_COL16;
            end
         end
         ST_COL16: begin
            bend_x_in = sat24(64'(bx_ff) + rnd_shift(64'(mul_p), 16) - 64'(offx_ff));
            mul_a     = 36'(it_res);
            mul_b     = 26'(my_c);
            state_in  = ST_COL17;
         end
         ST_COL17: begin
            bend_y_in = sat24(64'(by_ff) + rnd_shift(64'(mul_p), 16) - 64'(offy_ff));
            coll_in   = 1'b1;
            state_in  = ST_EMIT;
         end

         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, bend_on_ff, blink_on_ff, expired_ff, alive_ff,
                               bend_y_ff, bend_x_ff, bnc_y_ff, bnc_x_ff, coll_ff};
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         sx_ff        <= '0;
         sy_ff        <= '0;
         ex_ff        <= '0;
         ey_ff        <= '0;
         life_time_ff <= 24'd3000000;
         blink_per_ff <= 24'd100000;
         curve_per_ff <= 24'd50000;
         off_ff       <= 16'd2560;
         org_x_ff     <= '0;
         org_y_ff     <= '0;
         dir_x_ff     <= '0;
         dir_y_ff     <= '0;
         lensq_ff     <= '0;
         len_ff       <= '0;
         nrm_x_ff     <= '0;
         nrm_y_ff     <= '0;
         life_ff      <= '0;
         blink_t_ff   <= '0;
         bend_t_ff    <= '0;
         bend_x_ff    <= '0;
         bend_y_ff    <= '0;
         alive_ff     <= 1'b0;
         expired_ff   <= 1'b0;
         hit_ff       <= 1'b0;
         blinking_ff  <= 1'b0;
         blink_on_ff  <= 1'b0;
         bend_on_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         sx_ff        <= sx_in;
         sy_ff        <= sy_in;
         ex_ff        <= ex_in;
         ey_ff        <= ey_in;
         life_time_ff <= life_time_in;
         blink_per_ff <= blink_per_in;
         curve_per_ff <= curve_per_in;
         off_ff       <= off_in;
         org_x_ff     <= org_x_in;
         org_y_ff     <= org_y_in;
         dir_x_ff     <= dir_x_in;
         dir_y_ff     <= dir_y_in;
         lensq_ff     <= lensq_in;
         len_ff       <= len_in;
         nrm_x_ff     <= nrm_x_in;
         nrm_y_ff     <= nrm_y_in;
         life_ff      <= life_in;
         blink_t_ff   <= blink_t_in;
         bend_t_ff    <= bend_t_in;
         bend_x_ff    <= bend_x_in;
         bend_y_ff    <= bend_y_in;
         alive_ff     <= alive_in;
         expired_ff   <= expired_in;
         hit_ff       <= hit_in;
         blinking_ff  <= blinking_in;
         blink_on_ff  <= blink_on_in;
         bend_on_ff   <= bend_on_in;
      end
      elapsed_ff  <= elapsed_in;
      bx_ff       <= bx_in;
      by_ff       <= by_in;
      bnx_ff      <= bnx_in;
      bny_ff      <= bny_in;
      rad_ff      <= rad_in;
      acc_ff      <= acc_in;
      dn_ff       <= dn_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      snx_ff      <= snx_in;
      sny_ff      <= sny_in;
      gnx_ff      <= gnx_in;
      gny_ff      <= gny_in;
      offx_ff     <= offx_in;
      offy_ff     <= offy_in;
      bnc_x_ff    <= bnc_x_in;
      bnc_y_ff    <= bnc_y_in;
      coll_ff     <= coll_in;
      rsp_data_ff <= rsp_data_in;
   end

   `SCSB_ASSERT_IMP(a_expired_dead, expired_ff, !alive_ff, "expired line still alive")
   `SCSB_ASSERT_IMP(a_hit_blinks, hit_ff, blinking_ff, "hit line not blinking")
   `SCSB_ASSERT_IMP(a_idle_unit, state_ff == ST_IDLE, !it_busy, "div/sqrt busy while idle")
   `SCSB_ASSERT_NXT(a_one_item, req_tvalid && req_tready, !req_tready, "second item taken")
   `SCSB_ASSERT_IMP(a_hit_bend, rsp_tvalid && rsp_tdata[0], rsp_tdata[100], "hit without bend")

endmodule
